### rtl/sfs_pkg.sv
package sfs_pkg;

   localparam int MAX_FRAMES = 16;
   localparam int SLOT_W     = $clog2(MAX_FRAMES);
   localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
   localparam int TILE_W     = 12;
   localparam int DUR_W      = 16;
   localparam int STEP_W     = 16;
   localparam int ACC_W      = 20;
   localparam int CELL_W     = 9;
   localparam int GAP_W      = 8;
   localparam int TCNT_W     = 13;
   localparam int SPEED_W    = 12;
   localparam int SPEED_FRAC = 8;
   localparam int MODE_W     = 2;
   localparam int RECT_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int DIV_W      = ACC_W;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

   localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
   localparam logic [RECT_W-1:0] RECT_MAX = {RECT_W{1'b1}};

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam int MODE_LOOP_BIT = 0;
   localparam int MODE_FLIP_BIT = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATLAS_COLUMNS    = 3'd0,
      CSR_CELL_WIDTH       = 3'd1,
      CSR_CELL_HEIGHT      = 3'd2,
      CSR_CELL_SPACING     = 3'd3,
      CSR_ATLAS_MARGIN     = 3'd4,
      CSR_ATLAS_TILE_COUNT = 3'd5,
      CSR_PLAY_SPEED       = 3'd6,
      CSR_PLAY_MODE        = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile;
      logic [DUR_W-1:0]  dur;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      entry_type         data;
   } tbl_wr_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

endpackage

### rtl/sfs_frame_table.sv
module sfs_frame_table (
   input  logic                            clock,
   input  sfs_pkg::tbl_wr_type             wr,
   input  logic [sfs_pkg::SLOT_W-1:0]      rd_addr,
   output sfs_pkg::entry_type              rd_data
);

   sfs_pkg::entry_type mem [sfs_pkg::MAX_FRAMES];
   sfs_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sfs_divider.sv
module sfs_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  sfs_pkg::div_req_type req,
   output sfs_pkg::div_rsp_type rsp
);

   logic                            busy_ff;
   logic                            done_ff;
   logic [sfs_pkg::DIV_CNT_W-1:0]   count_ff;
   logic [sfs_pkg::DIV_W-1:0]       rem_ff;
   logic [sfs_pkg::DIV_W-1:0]       quo_ff;
   logic [sfs_pkg::DIV_W-1:0]       dsr_ff;
   logic [sfs_pkg::DIV_W:0]         trial;
   logic [sfs_pkg::DIV_W:0]         diff;
   logic                            fits;

   // restoring step: one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[sfs_pkg::DIV_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_W);
            rem_ff   <= '0;
            quo_ff   <= req.dividend;
            dsr_ff   <= req.divisor;
         end else if (busy_ff) begin
            rem_ff   <= fits ? diff[sfs_pkg::DIV_W-1:0] : trial[sfs_pkg::DIV_W-1:0];
            quo_ff   <= {quo_ff[sfs_pkg::DIV_W-2:0], fits};
            count_ff <= count_ff - 1'b1;
            if (count_ff == sfs_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("divider remainder not below divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");

endmodule

### rtl/sprite_frame_sequencer_unit.sv
// Sprite frame sequencer: one item at a time, req_ready is low while an item is at work.
// Load item: writes the table entry, then re-sums the durations of the loaded frames.
// Tick item: walks the table one entry at a time, with a last address step when it runs off the end,
//   plus a divider run for a wrap and another for a change to a valid tile (20-step serial divider).
// A new item is taken only back in S_IDLE, after the result is registered.
// Reset (synchronous, active high) clears state, loads register defaults; table is not cleared.
module sprite_frame_sequencer_unit (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [sfs_pkg::SLOT_W-1:0]         req_slot,
   input  logic [sfs_pkg::TILE_W-1:0]         req_frame_tile,
   input  logic [sfs_pkg::DUR_W-1:0]          req_frame_duration,
   input  logic                               req_final_entry,
   input  logic [sfs_pkg::STEP_W-1:0]         req_time_step,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sfs_pkg::SLOT_W-1:0]         rsp_current_frame,
   output logic                               rsp_frame_moved,
   output logic                               rsp_flip_horizontal,
   output logic [sfs_pkg::TILE_W-1:0]         rsp_shown_tile,
   output logic                               rsp_rect_valid,
   output logic [sfs_pkg::RECT_W-1:0]         rsp_rect_left,
   output logic [sfs_pkg::RECT_W-1:0]         rsp_rect_top,
   output logic [sfs_pkg::CELL_W-1:0]         rsp_rect_width,
   output logic [sfs_pkg::CELL_W-1:0]         rsp_rect_height,

   input  logic                               csr_wr_en,
   input  logic [sfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD_WR,
      S_SUM_ADDR,
      S_SUM_ACC,
      S_ACC,
      S_WRAP,
      S_WALK_ADDR,
      S_WALK_CMP,
      S_DIV_RC,
      S_MUL_L,
      S_MUL_T,
      S_RECT_T,
      S_SHOW,
      S_DONE
   } state_type;

   localparam int PROD_W  = sfs_pkg::SPEED_W + sfs_pkg::STEP_W;
   localparam int MULA_W  = sfs_pkg::TILE_W;
   localparam int MULB_W  = sfs_pkg::CELL_W + 1;
   localparam int MPROD_W = MULA_W + MULB_W;

   state_type state_ff;

   // configuration registers
   logic [sfs_pkg::CELL_W-1:0]  atlas_columns_ff;
   logic [sfs_pkg::CELL_W-1:0]  cell_width_ff;
   logic [sfs_pkg::CELL_W-1:0]  cell_height_ff;
   logic [sfs_pkg::GAP_W-1:0]   cell_spacing_ff;
   logic [sfs_pkg::GAP_W-1:0]   atlas_margin_ff;
   logic [sfs_pkg::TCNT_W-1:0]  atlas_tile_count_ff;
   logic [sfs_pkg::SPEED_W-1:0] play_speed_ff;
   logic [sfs_pkg::MODE_W-1:0]  play_mode_ff;

   // animation state
   logic [sfs_pkg::COUNT_W-1:0] frame_count_ff;
   logic [sfs_pkg::ACC_W-1:0]   total_ff;
   logic [sfs_pkg::ACC_W-1:0]   elapsed_ff;
   logic [sfs_pkg::SLOT_W-1:0]  frame_now_ff;
   logic                        flip_ff;

   // per-item working registers
   logic [sfs_pkg::SLOT_W-1:0]  slot_ff;
   sfs_pkg::entry_type          entry_ff;
   logic                        final_ff;
   logic [PROD_W-1:0]           prod_ff;
   logic [sfs_pkg::COUNT_W-1:0] idx_ff;
   logic [sfs_pkg::ACC_W-1:0]   acc_ff;
   logic                        changed_ff;
   logic                        rvalid_ff;
   logic [sfs_pkg::CELL_W-1:0]  col_ff;
   logic [sfs_pkg::TILE_W-1:0]  row_ff;
   logic [MPROD_W-1:0]          mprod_ff;
   logic [sfs_pkg::RECT_W-1:0]  rl_ff;
   logic [sfs_pkg::RECT_W-1:0]  rt_ff;

   // result register
   logic                        rsp_valid_ff;
   logic [sfs_pkg::SLOT_W-1:0]  rsp_frame_ff;
   logic                        rsp_changed_ff;
   logic                        rsp_flip_ff;
   logic [sfs_pkg::TILE_W-1:0]  rsp_tile_ff;
   logic                        rsp_rvalid_ff;
   logic [sfs_pkg::RECT_W-1:0]  rsp_left_ff;
   logic [sfs_pkg::RECT_W-1:0]  rsp_top_ff;
   logic [sfs_pkg::CELL_W-1:0]  rsp_width_ff;
   logic [sfs_pkg::CELL_W-1:0]  rsp_height_ff;

   // table and divider hookup
   sfs_pkg::tbl_wr_type         tbl_wr;
   logic [sfs_pkg::SLOT_W-1:0]  tbl_rd_addr;
   sfs_pkg::entry_type          tbl_rd;
   sfs_pkg::div_req_type        div_req;
   sfs_pkg::div_rsp_type        div_rsp;

   // datapath
   logic [sfs_pkg::ACC_W-1:0]   delta;
   logic [sfs_pkg::ACC_W:0]     elapsed_sum;
   logic [sfs_pkg::ACC_W-1:0]   elapsed_in;
   logic [sfs_pkg::ACC_W:0]     total_sum;
   logic [sfs_pkg::ACC_W-1:0]   acc_in;
   logic                        walk_pass;
   logic                        walk_move;
   logic                        tile_ok;
   logic [sfs_pkg::CELL_W-1:0]  cols_eff;
   logic [MULA_W-1:0]           mul_a;
   logic [MULB_W-1:0]           mul_b;
   logic [MPROD_W:0]            rect_sum;
   logic [sfs_pkg::RECT_W-1:0]  rect_in;
   logic                        out_free;

   sfs_frame_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd)
   );

   sfs_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // accumulator step: truncated speed * step in 8 fraction bits, saturate
   assign delta       = prod_ff[sfs_pkg::SPEED_FRAC +: sfs_pkg::ACC_W];
   assign elapsed_sum = {1'b0, elapsed_ff} + {1'b0, delta};
   assign elapsed_in  = elapsed_sum[sfs_pkg::ACC_W] ? sfs_pkg::ACC_MAX
                                                    : elapsed_sum[sfs_pkg::ACC_W-1:0];

   // duration sum over the table, saturating
   assign total_sum = {1'b0, acc_ff} + (sfs_pkg::ACC_W + 1)'(tbl_rd.dur);
   assign acc_in    = total_sum[sfs_pkg::ACC_W] ? sfs_pkg::ACC_MAX
                                                : total_sum[sfs_pkg::ACC_W-1:0];

   // frame walk: skip while the remaining time covers this frame
   assign walk_pass = acc_ff >= sfs_pkg::ACC_W'(tbl_rd.dur);
   assign walk_move = !walk_pass && (idx_ff[sfs_pkg::SLOT_W-1:0] != frame_now_ff);
   assign tile_ok   = {1'b0, tbl_rd.tile} < atlas_tile_count_ff;
   assign cols_eff  = (atlas_columns_ff == '0) ? sfs_pkg::CELL_W'(1) : atlas_columns_ff;

   // shared serial divider: wrap modulo on ticks, then column / row of the tile
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = elapsed_in;
      div_req.divisor  = total_ff;
      if (state_ff == S_ACC) begin
         div_req.start = (elapsed_in >= total_ff) && play_mode_ff[sfs_pkg::MODE_LOOP_BIT];
      end else if (state_ff == S_WALK_CMP) begin
         div_req.start    = walk_move && tile_ok;
         div_req.dividend = sfs_pkg::DIV_W'(tbl_rd.tile);
         div_req.divisor  = sfs_pkg::DIV_W'(cols_eff);
      end
   end

   // one multiplier for both rectangle axes
   always_comb begin
      if (state_ff == S_MUL_L) begin
         mul_a = MULA_W'(col_ff);
         mul_b = MULB_W'(cell_width_ff) + MULB_W'(cell_spacing_ff);
      end else begin
         mul_a = row_ff;
         mul_b = MULB_W'(cell_height_ff) + MULB_W'(cell_spacing_ff);
      end
   end

   assign rect_sum = {1'b0, mprod_ff} + (MPROD_W + 1)'(atlas_margin_ff);
   assign rect_in  = (rect_sum > (MPROD_W + 1)'(sfs_pkg::RECT_MAX)) ? sfs_pkg::RECT_MAX
                                                                     : rect_sum[sfs_pkg::RECT_W-1:0];

   always_comb begin
      tbl_wr.en   = (state_ff == S_LOAD_WR);
      tbl_wr.addr = slot_ff;
      tbl_wr.data = entry_ff;
   end

   // one read port: walk and sum index the table, otherwise read the shown frame
   always_comb begin
      if (state_ff == S_SUM_ADDR || state_ff == S_WALK_ADDR) begin
         tbl_rd_addr = idx_ff[sfs_pkg::SLOT_W-1:0];
      end else begin
         tbl_rd_addr = frame_now_ff;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_columns_ff    <= sfs_pkg::CELL_W'(1);
         cell_width_ff       <= sfs_pkg::CELL_W'(16);
         cell_height_ff      <= sfs_pkg::CELL_W'(16);
         cell_spacing_ff     <= '0;
         atlas_margin_ff     <= '0;
         atlas_tile_count_ff <= sfs_pkg::TCNT_W'(1);
         play_speed_ff       <= sfs_pkg::SPEED_W'(256);
         play_mode_ff        <= sfs_pkg::MODE_W'(1);
      end else if (csr_wr_en) begin
         unique case (sfs_pkg::csr_index_type'(csr_index))
            sfs_pkg::CSR_ATLAS_COLUMNS:    atlas_columns_ff <= csr_wdata[sfs_pkg::CELL_W-1:0];
            sfs_pkg::CSR_CELL_WIDTH:       cell_width_ff    <= csr_wdata[sfs_pkg::CELL_W-1:0];
            sfs_pkg::CSR_CELL_HEIGHT:      cell_height_ff   <= csr_wdata[sfs_pkg::CELL_W-1:0];
            sfs_pkg::CSR_CELL_SPACING:     cell_spacing_ff  <= csr_wdata[sfs_pkg::GAP_W-1:0];
            sfs_pkg::CSR_ATLAS_MARGIN:     atlas_margin_ff  <= csr_wdata[sfs_pkg::GAP_W-1:0];
            sfs_pkg::CSR_ATLAS_TILE_COUNT: atlas_tile_count_ff <= csr_wdata;
            sfs_pkg::CSR_PLAY_SPEED:       play_speed_ff    <= csr_wdata[sfs_pkg::SPEED_W-1:0];
            sfs_pkg::CSR_PLAY_MODE:        play_mode_ff     <= csr_wdata[sfs_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         frame_count_ff <= '0;
         total_ff       <= '0;
         elapsed_ff     <= '0;
         frame_now_ff   <= '0;
         flip_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // drop the result once taken; in S_DONE the next result takes its place
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  slot_ff       <= req_slot;
                  entry_ff.tile <= req_frame_tile;
                  entry_ff.dur  <= req_frame_duration;
                  final_ff      <= req_final_entry;
                  prod_ff       <= PROD_W'(play_speed_ff) * PROD_W'(req_time_step);
                  changed_ff    <= 1'b0;
                  rvalid_ff     <= 1'b0;
                  rl_ff         <= '0;
                  rt_ff         <= '0;
                  if (req_command == sfs_pkg::CMD_LOAD) begin
                     state_ff <= S_LOAD_WR;
                  end else if (frame_count_ff == '0 || total_ff == '0) begin
                     // nothing to play: report the state as it is
                     state_ff <= S_SHOW;
                  end else begin
                     state_ff <= S_ACC;
                  end
               end
            end
            S_LOAD_WR: begin
               if (final_ff) begin
                  frame_count_ff <= sfs_pkg::COUNT_W'(slot_ff) + 1'b1;
               end
               idx_ff   <= '0;
               acc_ff   <= '0;
               state_ff <= S_SUM_ADDR;
            end
            S_SUM_ADDR: begin
               if (idx_ff >= frame_count_ff) begin
                  total_ff <= acc_ff;
                  state_ff <= S_SHOW;
               end else begin
                  state_ff <= S_SUM_ACC;
               end
            end
            S_SUM_ACC: begin
               acc_ff   <= acc_in;
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_SUM_ADDR;
            end
            S_ACC: begin
               idx_ff <= '0;
               if (elapsed_in >= total_ff) begin
                  if (play_mode_ff[sfs_pkg::MODE_LOOP_BIT]) begin
                     // wrap: divider started this cycle
                     if (play_mode_ff[sfs_pkg::MODE_FLIP_BIT]) begin
                        flip_ff <= !flip_ff;
                     end
                     state_ff <= S_WRAP;
                  end else begin
                     elapsed_ff <= total_ff;
                     acc_ff     <= total_ff;
                     state_ff   <= S_WALK_ADDR;
                  end
               end else begin
                  elapsed_ff <= elapsed_in;
                  acc_ff     <= elapsed_in;
                  state_ff   <= S_WALK_ADDR;
               end
            end
            S_WRAP: begin
               if (div_rsp.done) begin
                  elapsed_ff <= div_rsp.remainder;
                  acc_ff     <= div_rsp.remainder;
                  state_ff   <= S_WALK_ADDR;
               end
            end
            S_WALK_ADDR: begin
               // past the last frame: holding at the end, frame stays
               state_ff <= (idx_ff >= frame_count_ff) ? S_SHOW : S_WALK_CMP;
            end
            S_WALK_CMP: begin
               if (walk_pass) begin
                  acc_ff   <= acc_ff - sfs_pkg::ACC_W'(tbl_rd.dur);
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_WALK_ADDR;
               end else if (walk_move) begin
                  frame_now_ff <= idx_ff[sfs_pkg::SLOT_W-1:0];
                  changed_ff   <= 1'b1;
                  state_ff     <= tile_ok ? S_DIV_RC : S_SHOW;
               end else begin
                  state_ff <= S_SHOW;
               end
            end
            S_DIV_RC: begin
               if (div_rsp.done) begin
                  col_ff   <= div_rsp.remainder[sfs_pkg::CELL_W-1:0];
                  row_ff   <= div_rsp.quotient[sfs_pkg::TILE_W-1:0];
                  state_ff <= S_MUL_L;
               end
            end
            S_MUL_L: begin
               mprod_ff <= MPROD_W'(mul_a) * MPROD_W'(mul_b);
               state_ff <= S_MUL_T;
            end
            S_MUL_T: begin
               rl_ff    <= rect_in;
               mprod_ff <= MPROD_W'(mul_a) * MPROD_W'(mul_b);
               state_ff <= S_RECT_T;
            end
            S_RECT_T: begin
               rt_ff     <= rect_in;
               rvalid_ff <= 1'b1;
               state_ff  <= S_SHOW;
            end
            S_SHOW: begin
               // table read of the shown frame lands next cycle
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_frame_ff   <= frame_now_ff;
                  rsp_changed_ff <= changed_ff;
                  rsp_flip_ff    <= flip_ff;
                  rsp_tile_ff    <= tbl_rd.tile;
                  rsp_rvalid_ff  <= rvalid_ff;
                  rsp_left_ff    <= rl_ff;
                  rsp_top_ff     <= rt_ff;
                  rsp_width_ff   <= rvalid_ff ? cell_width_ff : '0;
                  rsp_height_ff  <= rvalid_ff ? cell_height_ff : '0;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_current_frame   = rsp_frame_ff;
   assign rsp_frame_moved     = rsp_changed_ff;
   assign rsp_flip_horizontal = rsp_flip_ff;
   assign rsp_shown_tile      = rsp_tile_ff;
   assign rsp_rect_valid      = rsp_rvalid_ff;
   assign rsp_rect_left       = rsp_left_ff;
   assign rsp_rect_top        = rsp_top_ff;
   assign rsp_rect_width      = rsp_width_ff;
   assign rsp_rect_height     = rsp_height_ff;

   a_rect_needs_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rvalid_ff) |-> rsp_changed_ff)
      else $error("rectangle reported without a frame change");

   a_no_rect_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_rvalid_ff) |->
         (rsp_left_ff == '0 && rsp_top_ff == '0 && rsp_width_ff == '0 && rsp_height_ff == '0))
      else $error("rectangle fields not cleared");

   a_wrap_below_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRAP && div_rsp.done) |-> (div_rsp.remainder < total_ff))
      else $error("wrapped accumulator not below total");

   a_new_frame_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK_CMP && walk_move) |=>
         (sfs_pkg::COUNT_W'(frame_now_ff) < frame_count_ff))
      else $error("frame index beyond frame count");

endmodule
